### hdl/docc_pkg.sv
// shared constants, types and functions of the dynamic occupancy cell colouriser
package docc_pkg;

    localparam int FIELD_W      = 16;
    localparam int SPEED_W      = 15;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 16;
    localparam int CORDIC_STEPS = 18;
    localparam int MOT_LAT      = 4;
    localparam int SPD_LAT      = 2 + SQRT_STEPS + 1 + DIV_STEPS;
    localparam int COR_LAT      = 1 + CORDIC_STEPS + 1;
    localparam int HSV_LAT      = 2;
    localparam int TOTAL_LAT    = SPD_LAT + HSV_LAT;
    localparam int MOT_DLY      = SPD_LAT - MOT_LAT;
    localparam int COR_DLY      = SPD_LAT - COR_LAT;

    localparam int ANG_W = 22;
    localparam int VEC_W = 34;

    localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(393216);
    localparam logic signed [ANG_W-1:0] FULL_TURN = ANG_W'(786432);

    localparam logic [1:0] CFG_OCC_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_MOT_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_FULL_SPEED = 2'd2;

    typedef struct packed {
        logic [2:0]         sector;
        logic [FIELD_W-1:0] frac;
    } hue_t;

    function automatic logic signed [ANG_W-1:0] arc_of(input int k);
        logic signed [ANG_W-1:0] r;
        case (k)
            0:       r = ANG_W'(98304);
            1:       r = ANG_W'(58032);
            2:       r = ANG_W'(30663);
            3:       r = ANG_W'(15565);
            4:       r = ANG_W'(7813);
            5:       r = ANG_W'(3910);
            6:       r = ANG_W'(1956);
            7:       r = ANG_W'(978);
            8:       r = ANG_W'(489);
            9:       r = ANG_W'(244);
            10:      r = ANG_W'(122);
            11:      r = ANG_W'(61);
            12:      r = ANG_W'(31);
            13:      r = ANG_W'(15);
            14:      r = ANG_W'(8);
            15:      r = ANG_W'(4);
            16:      r = ANG_W'(2);
            17:      r = ANG_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### hdl/docc_motion.sv
// occupancy, grey level and motion test pipeline
module docc_motion
    import docc_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic        [FIELD_W-1:0]  mass_free,
    input  logic        [FIELD_W-1:0]  mass_occupied,
    input  logic signed [FIELD_W-1:0]  speed_x,
    input  logic signed [FIELD_W-1:0]  speed_y,
    input  logic        [FIELD_W-1:0]  variance_x,
    input  logic        [FIELD_W-1:0]  variance_y,
    input  logic signed [FIELD_W-1:0]  covariance_xy,
    input  logic        [FIELD_W-1:0]  occupancy_limit,
    input  logic        [FIELD_W-1:0]  motion_limit,
    output logic                       dyn,
    output logic        [FIELD_W-1:0]  grey
);

    // stage 1
    logic        [30:0] vx2_reg, vy2_reg, c2_reg;
    logic signed [31:0] vxvy_reg;
    logic        [31:0] vv_reg;
    logic        [15:0] varx1_reg, vary1_reg;
    logic signed [15:0] cov1_reg;
    logic        [15:0] occ1_reg, grey1_reg;
    logic signed [31:0] vx2_s, vy2_s, c2_s, vxvy_s;
    logic        [16:0] osum;
    logic        [15:0] occ_n;

    assign vx2_s  = speed_x * speed_x;
    assign vy2_s  = speed_y * speed_y;
    assign c2_s   = covariance_xy * covariance_xy;
    assign vxvy_s = speed_x * speed_y;
    assign osum   = 17'h10000 + {1'b0, mass_occupied} - {1'b0, mass_free};
    assign occ_n  = osum[16:1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx2_reg   <= vx2_s[30:0];
            vy2_reg   <= vy2_s[30:0];
            c2_reg    <= c2_s[30:0];
            vxvy_reg  <= vxvy_s;
            vv_reg    <= variance_x * variance_y;
            varx1_reg <= variance_x;
            vary1_reg <= variance_y;
            cov1_reg  <= covariance_xy;
            occ1_reg  <= occ_n;
            grey1_reg <= (occ_n == '0) ? 16'hFFFF : 16'(17'h10000 - {1'b0, occ_n});
        end
    end

    // stage 2
    logic        [46:0] a_reg, c_reg;
    logic signed [47:0] b_reg;
    logic signed [32:0] det_reg;
    logic        [15:0] occ2_reg, grey2_reg;
    logic signed [47:0] b_next;

    assign b_next = vxvy_reg * cov1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= {16'b0, vx2_reg} * {31'b0, vary1_reg};
            c_reg     <= {16'b0, vy2_reg} * {31'b0, varx1_reg};
            b_reg     <= b_next;
            det_reg   <= $signed({1'b0, vv_reg}) - $signed({2'b0, c2_reg});
            occ2_reg  <= occ1_reg;
            grey2_reg <= grey1_reg;
        end
    end

    // stage 3
    logic signed [49:0] num_reg;
    logic        [47:0] md_reg;
    logic               detpos_reg;
    logic        [15:0] occ3_reg, grey3_reg;
    logic signed [49:0] b_ext;

    assign b_ext = {{2{b_reg[47]}}, b_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg    <= $signed({3'b0, a_reg}) - (b_ext <<< 1) + $signed({3'b0, c_reg});
            md_reg     <= {32'b0, motion_limit} * {16'b0, det_reg[31:0]};
            detpos_reg <= !det_reg[32] && (det_reg != '0);
            occ3_reg   <= occ2_reg;
            grey3_reg  <= grey2_reg;
        end
    end

    // stage 4
    logic        dyn_reg;
    logic [15:0] grey4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dyn_reg   <= detpos_reg && (num_reg >= $signed({2'b0, md_reg}))
                         && (occ3_reg >= occupancy_limit);
            grey4_reg <= grey3_reg;
        end
    end

    assign dyn  = dyn_reg;
    assign grey = grey4_reg;

endmodule

### hdl/docc_speed.sv
// speed magnitude over full speed: square root then restoring division
module docc_speed
    import docc_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [FIELD_W-1:0] speed_x,
    input  logic signed [FIELD_W-1:0] speed_y,
    input  logic        [SPEED_W-1:0] full_speed,
    output logic        [FIELD_W-1:0] value
);

    logic        [30:0] vx2_reg, vy2_reg;
    logic signed [31:0] vx2_s, vy2_s;

    assign vx2_s = speed_x * speed_x;
    assign vy2_s = speed_y * speed_y;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx2_reg <= vx2_s[30:0];
            vy2_reg <= vy2_s[30:0];
        end
    end

    logic [31:0] rad_reg  [0:SQRT_STEPS];
    logic [32:0] rem_reg  [0:SQRT_STEPS];
    logic [31:0] root_reg [0:SQRT_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= {1'b0, vx2_reg} + {1'b0, vy2_reg};
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        logic [34:0] cur;
        logic [34:0] trial;
        logic        take;

        assign cur   = {rem_reg[i], rad_reg[i][31:30]};
        assign trial = {1'b0, root_reg[i], 2'b01};
        assign take  = cur >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i+1]  <= {rad_reg[i][29:0], 2'b00};
                rem_reg[i+1]  <= take ? 33'(cur - trial) : cur[32:0];
                root_reg[i+1] <= {root_reg[i][30:0], take};
            end
        end
    end

    logic [15:0] drem_reg [0:DIV_STEPS];
    logic [15:0] low_reg  [0:DIV_STEPS];
    logic [15:0] quo_reg  [0:DIV_STEPS];
    logic        sat_reg  [0:DIV_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0]  <= (full_speed == '0)
                           || ({1'b0, root_reg[SQRT_STEPS]} >= {2'b0, full_speed, 16'b0});
            drem_reg[0] <= root_reg[SQRT_STEPS][31:16];
            low_reg[0]  <= root_reg[SQRT_STEPS][15:0];
            quo_reg[0]  <= '0;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [16:0] cur;
        logic        take;

        assign cur  = {drem_reg[j], low_reg[j][15]};
        assign take = cur >= {2'b0, full_speed};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[j+1] <= take ? 16'(cur - {2'b0, full_speed}) : cur[15:0];
                low_reg[j+1]  <= {low_reg[j][14:0], 1'b0};
                quo_reg[j+1]  <= {quo_reg[j][14:0], take};
                sat_reg[j+1]  <= sat_reg[j];
            end
        end
    end

    assign value = sat_reg[DIV_STEPS] ? 16'hFFFF : quo_reg[DIV_STEPS];

endmodule

### hdl/docc_cordic.sv
// pipelined cordic vectoring giving hue sector and fraction
module docc_cordic
    import docc_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [FIELD_W-1:0] speed_x,
    input  logic signed [FIELD_W-1:0] speed_y,
    output hue_t                      hue
);

    logic signed [VEC_W-1:0] a_reg [0:CORDIC_STEPS];
    logic signed [VEC_W-1:0] b_reg [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] z_reg [0:CORDIC_STEPS];
    logic signed [VEC_W-1:0] xs, ys;

    assign xs = VEC_W'(speed_x) <<< 14;
    assign ys = VEC_W'(speed_y) <<< 14;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (xs > 0)
            begin
                a_reg[0] <= xs;
                b_reg[0] <= ys;
                z_reg[0] <= HALF_TURN;
            end
            else
            begin
                a_reg[0] <= -xs;
                b_reg[0] <= -ys;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_rot
        logic signed [VEC_W-1:0] da, db;

        assign da = b_reg[k] >>> k;
        assign db = a_reg[k] >>> k;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (b_reg[k] > 0)
                begin
                    a_reg[k+1] <= a_reg[k] + da;
                    b_reg[k+1] <= b_reg[k] - db;
                    z_reg[k+1] <= z_reg[k] + arc_of(k);
                end
                else
                begin
                    a_reg[k+1] <= a_reg[k] - da;
                    b_reg[k+1] <= b_reg[k] + db;
                    z_reg[k+1] <= z_reg[k] - arc_of(k);
                end
            end
        end
    end

    hue_t                    hue_reg;
    logic signed [ANG_W-1:0] ph;
    logic        [3:0]       sec_raw;

    assign ph      = z_reg[CORDIC_STEPS][ANG_W-1] ? z_reg[CORDIC_STEPS] + FULL_TURN
                                                  : z_reg[CORDIC_STEPS];
    assign sec_raw = ph[19:16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg.sector <= (sec_raw >= 4'd6) ? 3'(sec_raw - 4'd6) : sec_raw[2:0];
            hue_reg.frac   <= ph[15:0];
        end
    end

    assign hue = hue_reg;

endmodule

### hdl/docc_hsv.sv
// hsv to rgb with full saturation, or grey for static cells
module docc_hsv
    import docc_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic               dyn,
    input  logic [FIELD_W-1:0] grey,
    input  logic [FIELD_W-1:0] value,
    input  hue_t               hue,
    output logic [FIELD_W-1:0] red,
    output logic [FIELD_W-1:0] green,
    output logic [FIELD_W-1:0] blue
);

    logic [15:0] q_reg, t_reg, v_reg, grey_reg;
    logic [2:0]  sec_reg;
    logic        dyn_reg;
    logic [32:0] qp, tp;

    assign qp = {17'b0, value} * (33'h10000 - {17'b0, hue.frac});
    assign tp = {17'b0, value} * {17'b0, hue.frac};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg    <= qp[31:16];
            t_reg    <= tp[31:16];
            v_reg    <= value;
            sec_reg  <= hue.sector;
            dyn_reg  <= dyn;
            grey_reg <= grey;
        end
    end

    logic [15:0] r_reg, g_reg, b_reg;
    logic [15:0] r_next, g_next, b_next;

    always_comb
    begin
        r_next = grey_reg;
        g_next = grey_reg;
        b_next = grey_reg;
        if (dyn_reg)
        begin
            case (sec_reg)
                3'd0:
                begin
                    r_next = v_reg; g_next = t_reg; b_next = '0;
                end
                3'd1:
                begin
                    r_next = q_reg; g_next = v_reg; b_next = '0;
                end
                3'd2:
                begin
                    r_next = '0; g_next = v_reg; b_next = t_reg;
                end
                3'd3:
                begin
                    r_next = '0; g_next = q_reg; b_next = v_reg;
                end
                3'd4:
                begin
                    r_next = t_reg; g_next = '0; b_next = v_reg;
                end
                default:
                begin
                    r_next = v_reg; g_next = '0; b_next = q_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
        end
    end

    assign red   = r_reg;
    assign green = g_reg;
    assign blue  = b_reg;

endmodule

### hdl/dynamic_occupancy_cell_colorizer_core.sv
// top level of the dynamic occupancy cell colouriser
// Takes one grid cell per clock and gives one pixel per clock. The depth of the
// 53-stage pipeline is set by the 32-step square root and 16-step divider that
// scale the speed into the hsv value.
// The whole pipeline advances together and holds while the output item is not
// taken. Registers are written through cfg_we, cfg_index and cfg_data; later
// stages read them directly, so write them only while no item is in flight.
module dynamic_occupancy_cell_colorizer_core
    import docc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [FIELD_W-1:0]        cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [FIELD_W-1:0]        mass_free,
    input  logic [FIELD_W-1:0]        mass_occupied,
    input  logic signed [FIELD_W-1:0] speed_x,
    input  logic signed [FIELD_W-1:0] speed_y,
    input  logic [FIELD_W-1:0]        variance_x,
    input  logic [FIELD_W-1:0]        variance_y,
    input  logic signed [FIELD_W-1:0] covariance_xy,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [FIELD_W-1:0]        red,
    output logic [FIELD_W-1:0]        green,
    output logic [FIELD_W-1:0]        blue
);

    logic [FIELD_W-1:0] occ_limit_reg, mot_limit_reg;
    logic [SPEED_W-1:0] full_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_limit_reg  <= 16'd32768;
            mot_limit_reg  <= 16'd1024;
            full_speed_reg <= 15'd2560;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OCC_LIMIT:  occ_limit_reg  <= cfg_data;
                CFG_MOT_LIMIT:  mot_limit_reg  <= cfg_data;
                CFG_FULL_SPEED: full_speed_reg <= cfg_data[SPEED_W-1:0];
                default:        ;
            endcase
        end
    end

    logic                 en;
    logic [TOTAL_LAT-1:0] vld_reg;

    assign en       = !vld_reg[TOTAL_LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[TOTAL_LAT-1];

    logic               dyn_m;
    logic [FIELD_W-1:0] grey_m, value_s;
    hue_t               hue_c;

    docc_motion u_motion (
        .clk             (clk),
        .en              (en),
        .mass_free       (mass_free),
        .mass_occupied   (mass_occupied),
        .speed_x         (speed_x),
        .speed_y         (speed_y),
        .variance_x      (variance_x),
        .variance_y      (variance_y),
        .covariance_xy   (covariance_xy),
        .occupancy_limit (occ_limit_reg),
        .motion_limit    (mot_limit_reg),
        .dyn             (dyn_m),
        .grey            (grey_m)
    );

    docc_speed u_speed (
        .clk        (clk),
        .en         (en),
        .speed_x    (speed_x),
        .speed_y    (speed_y),
        .full_speed (full_speed_reg),
        .value      (value_s)
    );

    docc_cordic u_cordic (
        .clk     (clk),
        .en      (en),
        .speed_x (speed_x),
        .speed_y (speed_y),
        .hue     (hue_c)
    );

    // align motion and hue results with the speed value
    logic               dyn_dly_reg  [0:MOT_DLY-1];
    logic [FIELD_W-1:0] grey_dly_reg [0:MOT_DLY-1];
    hue_t               hue_dly_reg  [0:COR_DLY-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dyn_dly_reg[0]  <= dyn_m;
            grey_dly_reg[0] <= grey_m;
            hue_dly_reg[0]  <= hue_c;
            for (int i = 1; i < MOT_DLY; i++)
            begin
                dyn_dly_reg[i]  <= dyn_dly_reg[i-1];
                grey_dly_reg[i] <= grey_dly_reg[i-1];
            end
            for (int i = 1; i < COR_DLY; i++)
            begin
                hue_dly_reg[i] <= hue_dly_reg[i-1];
            end
        end
    end

    docc_hsv u_hsv (
        .clk   (clk),
        .en    (en),
        .dyn   (dyn_dly_reg[MOT_DLY-1]),
        .grey  (grey_dly_reg[MOT_DLY-1]),
        .value (value_s),
        .hue   (hue_dly_reg[COR_DLY-1]),
        .red   (red),
        .green (green),
        .blue  (blue)
    );

endmodule

### bench/dynamic_occupancy_cell_colorizer_core_tb.sv
// testbench for the dynamic occupancy cell colouriser: streamed cells, predicted pixels
module dynamic_occupancy_cell_colorizer_core_tb
    import docc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 600000;

    typedef struct {
        logic [15:0] mfree;
        logic [15:0] mocc;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] varx;
        logic [15:0] vary;
        logic [15:0] cov;
    } cell_t;

    typedef struct {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } pixel_t;

    class pixel_scoreboard;
        logic [15:0] occ_limit;
        logic [15:0] mot_limit;
        logic [14:0] speed_scale;
        pixel_t      pixels_due[$];
        int          errors;

        function new();
            occ_limit   = 16'd32768;
            mot_limit   = 16'd1024;
            speed_scale = 15'd2560;
            errors      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            if (idx == CFG_OCC_LIMIT)
                occ_limit = data;
            else if (idx == CFG_MOT_LIMIT)
                mot_limit = data;
            else if (idx == CFG_FULL_SPEED)
                speed_scale = data[14:0];
        endfunction

        function longint hue_phase(longint vx, longint vy);
            longint a;
            longint b;
            longint z;
            longint da;
            longint db;
            longint arc[18];
            arc = '{98304, 58032, 30663, 15565, 7813, 3910, 1956, 978, 489,
                    244, 122, 61, 31, 15, 8, 4, 2, 1};
            a = -vx * 16384;
            b = -vy * 16384;
            z = 0;
            if (a < 0)
            begin
                a = -a;
                b = -b;
                z = 393216;
            end
            for (int k = 0; k < 18; k++)
            begin
                da = b >>> k;
                db = a >>> k;
                if (b > 0)
                begin
                    a += da;
                    b -= db;
                    z += arc[k];
                end
                else
                begin
                    a -= da;
                    b += db;
                    z -= arc[k];
                end
            end
            while (z < 0)
                z += 786432;
            while (z >= 786432)
                z -= 786432;
            return z;
        endfunction

        function longint unsigned brightness(longint vx, longint vy);
            longint unsigned target;
            longint unsigned cand;
            longint unsigned prod;
            longint unsigned v;
            target = longint'(vx * vx + vy * vy) << 32;
            v = 0;
            for (int bit_i = 15; bit_i >= 0; bit_i--)
            begin
                cand = v | (64'd1 << bit_i);
                prod = cand * speed_scale;
                if (prod * prod <= target)
                    v = cand;
            end
            return v;
        endfunction

        function void note(cell_t c);
            longint mfree, mocc, vx, vy, varx, vary, cov, occ, det, num;
            longint unsigned v, f, q, t, grey, ph;
            int sector;
            pixel_t p;
            mfree = c.mfree;
            mocc  = c.mocc;
            vx    = $signed(c.vx);
            vy    = $signed(c.vy);
            varx  = c.varx;
            vary  = c.vary;
            cov   = $signed(c.cov);
            occ   = (65536 + mocc - mfree) / 2;
            det   = varx * vary - cov * cov;
            num   = vx * vx * vary - 2 * vx * vy * cov + vy * vy * varx;
            if (occ >= longint'(occ_limit) && det > 0 && num >= longint'(mot_limit) * det)
            begin
                ph = hue_phase(vx, vy);
                f = ph & 64'hFFFF;
                sector = int'((ph >> 16) % 6);
                v = brightness(vx, vy);
                q = (v * (65536 - f)) >> 16;
                t = (v * f) >> 16;
                case (sector)
                    0: p = '{16'(v), 16'(t), 16'h0};
                    1: p = '{16'(q), 16'(v), 16'h0};
                    2: p = '{16'h0, 16'(v), 16'(t)};
                    3: p = '{16'h0, 16'(q), 16'(v)};
                    4: p = '{16'(t), 16'h0, 16'(v)};
                    default: p = '{16'(v), 16'h0, 16'(q)};
                endcase
            end
            else
            begin
                grey = 65536 - occ;
                if (grey > 65535)
                    grey = 65535;
                p = '{16'(grey), 16'(grey), 16'(grey)};
            end
            pixels_due.push_back(p);
        endfunction

        function void check(logic [15:0] r, logic [15:0] g, logic [15:0] b);
            pixel_t e;
            if (pixels_due.size() == 0)
            begin
                $error("unexpected pixel %h %h %h", r, g, b);
                errors++;
                return;
            end
            e = pixels_due.pop_front();
            if (r !== e.r)
            begin
                $error("red expected %0d actual %0d", e.r, r);
                errors++;
            end
            if (g !== e.g)
            begin
                $error("green expected %0d actual %0d", e.g, g);
                errors++;
            end
            if (b !== e.b)
            begin
                $error("blue expected %0d actual %0d", e.b, b);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] mass_free = '0;
    logic [15:0] mass_occupied = '0;
    logic [15:0] speed_x = '0;
    logic [15:0] speed_y = '0;
    logic [15:0] variance_x = '0;
    logic [15:0] variance_y = '0;
    logic [15:0] covariance_xy = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;

    pixel_scoreboard sb = new();
    int cycles = 0;
    int burst_left = 0;

    dynamic_occupancy_cell_colorizer_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .mass_free(mass_free), .mass_occupied(mass_occupied),
        .speed_x(speed_x), .speed_y(speed_y),
        .variance_x(variance_x), .variance_y(variance_y),
        .covariance_xy(covariance_xy),
        .out_valid(out_valid), .out_ready(out_ready),
        .red(red), .green(green), .blue(blue)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("dynamic_occupancy_cell_colorizer_core test failed");
            $finish;
        end
        if (rst_n && in_valid && in_ready)
            sb.note('{mass_free, mass_occupied, speed_x, speed_y,
                      variance_x, variance_y, covariance_xy});
        if (rst_n && out_valid && out_ready)
            sb.check(red, green, blue);
    end

    // receiver stall pattern, changes mode every so often
    int stall_mode = 0;
    int mode_left = 0;
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ((cycles % 11) < 6);
        endcase
    end

    task automatic send_cell(cell_t c);
        @(negedge clk);
        in_valid      <= 1'b1;
        mass_free     <= c.mfree;
        mass_occupied <= c.mocc;
        speed_x       <= c.vx;
        speed_y       <= c.vy;
        variance_x    <= c.varx;
        variance_y    <= c.vary;
        covariance_xy <= c.cov;
        do
            @(posedge clk);
        while (!in_ready);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(0, 8))
                    @(negedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pixels_due.size() != 0)
            @(negedge clk);
        repeat (TOTAL_LAT + 4)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    function automatic cell_t random_cell();
        cell_t c;
        int lim;
        c.mfree = 16'($urandom);
        c.mocc  = 16'($urandom);
        c.vx    = 16'($urandom);
        c.vy    = 16'($urandom);
        c.varx  = 16'($urandom);
        c.vary  = 16'($urandom);
        c.cov   = 16'($urandom);
        case ($urandom_range(0, 9))
            0, 1:
            begin
            end
            default:
            begin
                // mostly moving, well occupied cells
                c.mfree = 16'($urandom_range(0, 12000));
                c.mocc  = 16'($urandom_range(30000, 65535));
                c.varx  = 16'($urandom_range(1, 3000));
                c.vary  = 16'($urandom_range(1, 3000));
                lim = int'((c.varx < c.vary) ? c.varx : c.vary) / 2;
                c.cov   = 16'($urandom_range(0, 2 * lim) - lim);
                if ($urandom_range(0, 1) == 1)
                begin
                    c.vx = 16'($urandom_range(0, 4000) - 2000);
                    c.vy = 16'($urandom_range(0, 4000) - 2000);
                end
            end
        endcase
        return c;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            send_cell(random_cell());
            if (i == n / 2 && $urandom_range(0, 1) == 1)
                drain();
        end
        drain();
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed cells
        send_cell('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_cell('{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_cell('{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0000});
        send_cell('{16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h7FFF});
        send_cell('{16'h0000, 16'hFFFF, 16'h8000, 16'h8000, 16'h0001, 16'h0001, 16'h0000});
        send_cell('{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h8000});
        send_cell('{16'h0000, 16'hFFFF, 16'h0200, 16'h0000, 16'h0100, 16'h0100, 16'h0100});
        send_cell('{16'h0000, 16'hFFFF, 16'h0200, 16'h0000, 16'h0100, 16'h0100, 16'h0000});
        send_cell('{16'h0000, 16'hFFFF, 16'h0000, 16'h0200, 16'h0100, 16'h0100, 16'h0000});
        send_cell('{16'h0000, 16'hFFFF, 16'hFE00, 16'h0000, 16'h0100, 16'h0100, 16'h0000});
        send_cell('{16'h0000, 16'hFFFF, 16'h0000, 16'hFE00, 16'h0100, 16'h0100, 16'h0000});
        send_cell('{16'h0000, 16'hFFFF, 16'h0300, 16'h0180, 16'h0100, 16'h0100, 16'h0040});
        send_cell('{16'h0000, 16'hFFFF, 16'hFD00, 16'h0180, 16'h0100, 16'h0100, 16'hFFC0});
        send_cell('{16'h0000, 16'hFFFF, 16'h0100, 16'hFD00, 16'h0100, 16'h0200, 16'h0000});
        send_cell('{16'h0000, 16'hFFFF, 16'h1000, 16'h1000, 16'h0010, 16'h0010, 16'h0000});
        send_cell('{16'h0000, 16'hFFFF, 16'h0010, 16'h0000, 16'h0100, 16'h0100, 16'h0000});
        send_cell('{16'h8000, 16'h8000, 16'h0400, 16'h0400, 16'h0100, 16'h0100, 16'h0000});
        send_cell('{16'h8001, 16'h8000, 16'h0400, 16'h0400, 16'h0100, 16'h0100, 16'h0000});
        drain();

        random_phase(350);
        write_reg(CFG_OCC_LIMIT, 16'h0000);
        write_reg(CFG_MOT_LIMIT, 16'h0000);
        write_reg(CFG_FULL_SPEED, 16'h0001);
        random_phase(350);
        write_reg(CFG_OCC_LIMIT, 16'hFFFF);
        write_reg(CFG_MOT_LIMIT, 16'hFFFF);
        write_reg(CFG_FULL_SPEED, 16'h7FFF);
        random_phase(250);
        // upper bit beyond the register width, and an index with no register
        write_reg(CFG_OCC_LIMIT, 16'h2000);
        write_reg(CFG_MOT_LIMIT, 16'h0080);
        write_reg(CFG_FULL_SPEED, 16'h8000);
        write_reg(2'd3, 16'h1234);
        random_phase(350);
        write_reg(CFG_OCC_LIMIT, 16'($urandom));
        write_reg(CFG_MOT_LIMIT, 16'($urandom_range(0, 4096)));
        write_reg(CFG_FULL_SPEED, 16'($urandom_range(1, 32767)) | 16'h8000);
        random_phase(600);

        if (sb.errors == 0)
            $display("dynamic_occupancy_cell_colorizer_core test passed");
        else
            $display("dynamic_occupancy_cell_colorizer_core test failed");
        $finish;
    end

endmodule
